// ----- src/clocked_frame_transmitter_with_fifo_defines.svh -----
// Assertion macros for the clocked frame transmitter.
// Included by the top level; no other dependencies.
`ifndef CLOCKED_FRAME_TRANSMITTER_WITH_FIFO_DEFINES_SVH
`define CLOCKED_FRAME_TRANSMITTER_WITH_FIFO_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CFT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CFT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CFT_ASSERT(label, clk, rst, prop, msg)
`define CFT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- src/cft_pkg.sv -----
// Shared types and constants of the clocked frame transmitter.
// No dependencies.
package cft_pkg;

   localparam int FIFO_DEPTH_DEFAULT = 32;

   localparam logic [3:0] MARK_LAST   = 4'd7;
   localparam logic [3:0] DATA_LAST   = 4'd8;
   localparam logic [3:0] PARITY_SLOT = 4'd9;
   localparam logic [3:0] STOP_SLOT   = 4'd10;

   typedef enum logic [2:0] {
      PH_MARKS = 3'b001,
      PH_TEST  = 3'b010,
      PH_DRAIN = 3'b100
   } phase_type;

   // Characters of the test group, in sending order
   function automatic logic [7:0] test_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = 8'h74;
         2'd1:    c = 8'h65;
         2'd2:    c = 8'h73;
         default: c = 8'h74;
      endcase
      return c;
   endfunction

endpackage

// ----- src/cft_req_if.sv -----
// Input channel: received bytes and bit clock edges.
// No dependencies.
interface cft_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] rx_byte;
   logic       test_request;

   modport source (output valid, output mode, output rx_byte, output test_request,
                   input ready);
   modport sink   (input valid, input mode, input rx_byte, input test_request,
                   output ready);
endinterface

// ----- src/cft_rsp_if.sv -----
// Result channel: line level and drop flag.
// No dependencies.
interface cft_rsp_if;
   logic valid;
   logic ready;
   logic line_bit;
   logic dropped;

   modport source (output valid, output line_bit, output dropped, input ready);
   modport sink   (input valid, input line_bit, input dropped, output ready);
endinterface

// ----- src/clocked_frame_transmitter_with_fifo.sv -----
// Top level of the clocked frame transmitter with receive buffer.
// Depends on cft_pkg, cft_req_if, cft_rsp_if and the defines header.
//
// Usage:
//   req_bus carries one word per event: mode 0 buffers rx_byte in a ring of
//   FIFO_DEPTH slots (FIFO_DEPTH-1 usable; a byte arriving on a full ring is
//   dropped and flagged), mode 1 marks a rising edge of the bit clock and
//   test_request is sampled at sequence decision points.
//   rsp_bus returns one word per request word: line_bit is the line level
//   after the event, dropped flags a discarded byte.
//   Frames: 8 mark bits, then 't','e','s','t' groups while test_request is
//   high, then the buffered bytes, each as start, 8 data LSB first, even
//   parity, stop.
//   The result is registered, valid the next cycle; one word is taken every
//   cycle unless rsp_bus stalls (one sequencer update and one ring access per
//   word). The ring head is prefetched from the buffer memory into a register.
//   Reset (synchronous) empties the ring, restarts the mark run and drives
//   the line high; buffer contents are not cleared.
//   When rsp_bus stalls, the result is held and req_bus.ready drops until
//   the result is taken; the next word is accepted in the cycle it is taken.
`include "clocked_frame_transmitter_with_fifo_defines.svh"

module clocked_frame_transmitter_with_fifo
   import cft_pkg::*;
#(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   cft_req_if.sink   req_bus,
   cft_rsp_if.source rsp_bus
);

   localparam int PTR_W = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

   logic [7:0] store_mem [FIFO_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_next, rd_next;
   phase_type        phase_ff, phase_in;
   logic [3:0]       slot_ff, slot_in;
   logic [7:0]       shift_ff, shift_in;
   logic             parity_ff, parity_in;
   logic [1:0]       pidx_ff, pidx_in;
   logic             line_ff, line_in;
   logic             rsp_valid_ff, line_bit_ff, dropped_ff;
   logic [7:0]       rd_data_ff, bypass_data_ff;
   logic             bypass_ff;

   logic       accept, ring_empty, ring_full, wr_en, drop;
   logic       do_bits, do_start, do_marks, pop, bit_v;
   logic [7:0] head, start_val;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;

   assign wr_next    = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_next    = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
   assign ring_empty = (wr_ptr_ff == rd_ptr_ff);
   assign ring_full  = (wr_next == rd_ptr_ff);
   assign head       = bypass_ff ? bypass_data_ff : rd_data_ff;

   always_comb begin
      phase_in  = phase_ff;
      slot_in   = slot_ff;
      shift_in  = shift_ff;
      parity_in = parity_ff;
      pidx_in   = pidx_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_en     = 1'b0;
      drop      = 1'b0;
      do_bits   = 1'b0;
      do_start  = 1'b0;
      do_marks  = 1'b0;
      pop       = 1'b0;
      start_val = head;
      bit_v     = line_ff;

      if (accept && !req_bus.mode) begin
         if (ring_full) begin
            drop = 1'b1;
         end else begin
            wr_en     = 1'b1;
            wr_ptr_in = wr_next;
         end
      end else if (accept) begin
         case (phase_ff)
            PH_TEST: begin
               if (slot_ff != '0) begin
                  do_bits = 1'b1;
               end else if (pidx_ff != '0) begin
                  do_start  = 1'b1;
                  start_val = test_char(pidx_ff);
               end else if (req_bus.test_request) begin
                  do_start  = 1'b1;
                  start_val = test_char(2'd0);
               end else if (!ring_empty) begin
                  phase_in = PH_DRAIN;
                  do_start = 1'b1;
                  pop      = 1'b1;
               end else begin
                  do_marks = 1'b1;
               end
            end
            PH_DRAIN: begin
               if (slot_ff != '0) begin
                  do_bits = 1'b1;
               end else if (!ring_empty) begin
                  do_start = 1'b1;
                  pop      = 1'b1;
               end else begin
                  do_marks = 1'b1;
               end
            end
            default: begin
               // mark run: hand over to the decision point after the eighth mark
               phase_in = PH_MARKS;
               bit_v    = 1'b1;
               if (slot_ff >= MARK_LAST) begin
                  phase_in = PH_TEST;
                  slot_in  = '0;
                  pidx_in  = '0;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end
         endcase

         if (do_start) begin
            shift_in  = start_val;
            parity_in = 1'b0;
            slot_in   = 4'd1;
            bit_v     = 1'b0;
         end
         if (do_marks) begin
            phase_in = PH_MARKS;
            slot_in  = 4'd1;
            bit_v    = 1'b1;
         end
         if (pop) begin
            rd_ptr_in = rd_next;
         end
         if (do_bits) begin
            if (slot_ff <= DATA_LAST) begin
               bit_v     = shift_ff[0];
               shift_in  = {1'b0, shift_ff[7:1]};
               parity_in = parity_ff ^ shift_ff[0];
               slot_in   = slot_ff + 1'b1;
            end else if (slot_ff == PARITY_SLOT) begin
               bit_v   = parity_ff;
               slot_in = STOP_SLOT;
            end else begin
               // stop bit; advance the test character
               bit_v   = 1'b1;
               slot_in = '0;
               if (phase_ff == PH_TEST) begin
                  pidx_in = pidx_ff + 1'b1;
               end
            end
         end
      end
      line_in = bit_v;
   end

   // Buffer memory with prefetched head and write bypass
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_ptr_ff] <= req_bus.rx_byte;
      end
      rd_data_ff     <= store_mem[rd_ptr_in];
      bypass_ff      <= wr_en && (wr_ptr_ff == rd_ptr_in);
      bypass_data_ff <= req_bus.rx_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         phase_ff     <= PH_MARKS;
         slot_ff      <= '0;
         shift_ff     <= '0;
         parity_ff    <= 1'b0;
         pidx_ff      <= '0;
         line_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         phase_ff  <= phase_in;
         slot_ff   <= slot_in;
         shift_ff  <= shift_in;
         parity_ff <= parity_in;
         pidx_ff   <= pidx_in;
         line_ff   <= line_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         line_bit_ff <= line_in;
         dropped_ff  <= drop;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.line_bit = line_bit_ff;
   assign rsp_bus.dropped  = dropped_ff;

   `CFT_ASSERT(a_drop_holds_ptr, clock, reset, accept && !req_bus.mode && ring_full |=> $stable(wr_ptr_ff) && rsp_bus.dropped, "dropped word moved the write pointer")
   `CFT_ASSERT(a_idle_holds_ptrs, clock, reset, !accept |=> $stable(wr_ptr_ff) && $stable(rd_ptr_ff), "ring pointers moved without a word")
   `CFT_ASSERT(a_stop_is_mark, clock, reset, accept && req_bus.mode && slot_ff == STOP_SLOT |=> rsp_bus.line_bit, "stop bit not driven high")

endmodule

// ----- verif/tb_clocked_frame_transmitter_with_fifo.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the clocked frame transmitter with receive buffer.
// Depends on cft_pkg, cft_req_if, cft_rsp_if and clocked_frame_transmitter_with_fifo.
module tb_clocked_frame_transmitter_with_fifo;
   import cft_pkg::*;

   localparam int RING_DEPTH = FIFO_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_EDGE = 1'b1;
   localparam logic [7:0] TEST_GROUP [4] = '{8'h74, 8'h65, 8'h73, 8'h74};

   typedef struct packed {
      logic line_bit;
      logic dropped;
   } line_word_type;

   logic clock;
   logic reset;

   cft_req_if req_bus();
   cft_rsp_if rsp_bus();

   clocked_frame_transmitter_with_fifo u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Transmitter state as predicted
   logic [7:0]  ring_mem [RING_DEPTH];
   int unsigned ring_wr;
   int unsigned ring_rd;
   phase_type   seq_phase;
   logic [3:0]  slot;
   logic [7:0]  shifter;
   logic        parity;
   logic [1:0]  char_idx;
   logic        held_line;

   line_word_type expected_words [$];
   int mismatches = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   always #2 clock = ~clock;

   function automatic int unsigned ptr_next(input int unsigned p);
      return (p + 1) % RING_DEPTH;
   endfunction

   function automatic logic [7:0] ring_take();
      logic [7:0] v;
      v = ring_mem[ring_rd];
      ring_rd = ptr_next(ring_rd);
      return v;
   endfunction

   function automatic logic start_char(input logic [7:0] v);
      shifter = v;
      parity = 1'b0;
      slot = 4'd1;
      return 1'b0;
   endfunction

   function automatic logic start_marks();
      seq_phase = PH_MARKS;
      slot = 4'd1;
      return 1'b1;
   endfunction

   function automatic logic frame_bit();
      logic b;
      if (slot >= 4'd1 && slot <= DATA_LAST) begin
         b = shifter[0];
         shifter = shifter >> 1;
         parity = parity ^ b;
         slot = slot + 4'd1;
         return b;
      end
      if (slot == PARITY_SLOT) begin
         slot = STOP_SLOT;
         return parity;
      end
      // stop bit; advance the group character when in a test group
      slot = 4'd0;
      if (seq_phase == PH_TEST) char_idx = char_idx + 2'd1;
      return 1'b1;
   endfunction

   function automatic logic bit_edge(input logic test_req);
      case (seq_phase)
         PH_TEST: begin
            if (slot != 4'd0) return frame_bit();
            if (char_idx != 2'd0) return start_char(TEST_GROUP[char_idx]);
            // decision point after marks or a full group
            if (test_req) return start_char(TEST_GROUP[0]);
            if (ring_wr != ring_rd) begin
               seq_phase = PH_DRAIN;
               return start_char(ring_take());
            end
            return start_marks();
         end
         PH_DRAIN: begin
            if (slot != 4'd0) return frame_bit();
            if (ring_wr != ring_rd) return start_char(ring_take());
            return start_marks();
         end
         default: begin
            seq_phase = PH_MARKS;
            if (slot >= MARK_LAST) begin
               seq_phase = PH_TEST;
               slot = 4'd0;
               char_idx = 2'd0;
            end else begin
               slot = slot + 4'd1;
            end
            return 1'b1;
         end
      endcase
   endfunction

   function automatic line_word_type predict_line_word(input logic m, input logic [7:0] b,
                                                       input logic test_req);
      line_word_type w;
      w.dropped = 1'b0;
      if (m == MODE_BYTE) begin
         if (ptr_next(ring_wr) == ring_rd) begin
            w.dropped = 1'b1;
         end else begin
            ring_mem[ring_wr] = b;
            ring_wr = ptr_next(ring_wr);
         end
      end else begin
         held_line = bit_edge(test_req);
      end
      w.line_bit = held_line;
      return w;
   endfunction

   task automatic send_word(input logic m, input logic [7:0] b, input logic test_req);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid        <= 1'b1;
      req_bus.mode         <= m;
      req_bus.rx_byte      <= b;
      req_bus.test_request <= test_req;
      do @(posedge clock); while (!req_bus.ready);
      expected_words.push_back(predict_line_word(m, b, test_req));
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   // Two extreme bytes buffered, then marks and a drain with the request low
   task automatic test_drain_extremes();
      send_word(MODE_BYTE, 8'h00, 1'b0);
      send_word(MODE_BYTE, 8'hFF, 1'b0);
      repeat (32) send_word(MODE_EDGE, 8'h00, 1'b0);
   endtask

   // Repeated test groups, a byte arriving mid-group, then a drain
   task automatic test_test_groups();
      repeat (50) send_word(MODE_EDGE, 8'hFF, 1'b1);
      send_word(MODE_BYTE, 8'hA5, 1'b1);
      repeat (60) send_word(MODE_EDGE, 8'h00, 1'b0);
   endtask

   // Fill the ring past its capacity so the last bytes are dropped
   task automatic test_ring_overflow();
      repeat (RING_DEPTH + 1) send_word(MODE_BYTE, 8'($urandom), 1'($urandom));
      repeat (6) send_word(MODE_EDGE, 8'($urandom), 1'b0);
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct,
                                      input int stall, input bit pause_midway);
      int sent;
      int len;
      int kind;
      logic req_level;
      send_idle_pct = idle_pct;
      stall_pct = stall;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(9);
         if (pause_midway && sent >= count / 2) begin
            wait_for_results();
            pause_midway = 1'b0;
         end
         if (kind <= 1) begin
            // burst of arrivals, long enough now and then to overflow the ring
            len = (kind == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
            repeat (len) send_word(MODE_BYTE, 8'($urandom), 1'($urandom));
         end else if (kind <= 7) begin
            len = $urandom_range(60, 1);
            req_level = ($urandom_range(99) < 30);
            repeat (len) send_word(MODE_EDGE, 8'($urandom), req_level);
         end else begin
            len = $urandom_range(20, 1);
            repeat (len) send_word(1'($urandom), 8'($urandom), 1'($urandom));
         end
         sent += len;
      end
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      line_word_type exp;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result word: line_bit %0b dropped %0b",
                   rsp_bus.line_bit, rsp_bus.dropped);
            mismatches++;
         end else begin
            exp = expected_words.pop_front();
            if (rsp_bus.line_bit !== exp.line_bit) begin
               $error("line_bit: expected %0b, got %0b", exp.line_bit, rsp_bus.line_bit);
               mismatches++;
            end
            if (rsp_bus.dropped !== exp.dropped) begin
               $error("dropped: expected %0b, got %0b", exp.dropped, rsp_bus.dropped);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_BYTE;
      req_bus.rx_byte = 8'h00;
      req_bus.test_request = 1'b0;
      rsp_bus.ready = 1'b0;
      ring_wr = 0;
      ring_rd = 0;
      seq_phase = PH_MARKS;
      slot = 4'd0;
      shifter = 8'h00;
      parity = 1'b0;
      char_idx = 2'd0;
      held_line = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_drain_extremes();
      test_test_groups();
      test_ring_overflow();
      test_random_traffic(360, 0, 0, 1'b1);
      test_random_traffic(360, 87, 0, 1'b0);
      test_random_traffic(360, 0, 87, 1'b0);
      test_random_traffic(360, 32, 32, 1'b0);

      wait_for_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
